// ----- hw/rtl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers for the sector frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int SECTOR_BYTES = 128;
    localparam int MAX_RETRIES  = 10;

    // Byte counter must be able to hold SECTOR_BYTES itself
    localparam int CNT_W = $clog2(SECTOR_BYTES + 1);
    localparam int SUM_W = 16;

    localparam logic [7:0] CH_SOH    = 8'h01;
    localparam logic [7:0] CH_EOT    = 8'h04;
    localparam logic [7:0] CH_CANCEL = 8'h58; // 'X'
    localparam logic [7:0] CH_NINE   = 8'h39; // '9'

    typedef enum logic [3:0] {
        ST_NONE    = 4'd0,
        ST_DATA    = 4'd1,
        ST_ACK     = 4'd2,
        ST_NAK     = 4'd3,
        ST_EOT     = 4'd4,
        ST_CANCEL  = 4'd5,
        ST_NOSOH   = 4'd6,
        ST_BADSEC  = 4'd7,
        ST_TOOMANY = 4'd8,
        ST_HALTED  = 4'd9
    } status_t;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SECTOR = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_CKSUM  = 5'b01000,
        PH_HALT   = 5'b10000
    } phase_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] data_byte;
        logic [6:0] data_index;
        logic [3:0] sector_number;
    } sfr_result_t;

    // Hex character to nibble: above '9' subtract '7', else subtract '0', mod 16
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        if (c > CH_NINE)
            v = c[3:0] - 4'h7;
        else
            v = c[3:0];
        return v;
    endfunction

endpackage

// ----- hw/rtl/sector_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// sector_frame_receiver_core
// Sector deframer: SOH, sector number, data bytes and folded checksum.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | in_valid, in_ready, rx_byte               | request in
//  result    | out_valid, out_ready, status, data_byte,  | request out
//            | data_index, sector_number                 |
//  config    | cfg_we, cfg_wdata (seven_bit_mode)        | write only
//
//  One request is accepted per cycle while in_ready is high; each result is registered.
//  The limit is the frame state machine, which updates in the accept cycle.
//  Reset clears the phase to awaiting header, expected sector to one.
//  Results sit in an output register backed by a skid stage; in_ready drops
//  only while both are occupied, so a stalled consumer costs no input cycle
//  until the second result is waiting.
//
module sector_frame_receiver_core
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] status,
    output logic [7:0] data_byte,
    output logic [6:0] data_index,
    output logic [3:0] sector_number
);

    logic        seven_bit_mode_reg;
    logic        accept;
    sfr_result_t engine_result;
    sfr_result_t out_result;

    // Mode register: write only while idle (the block does not enforce it); applies from the next request on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seven_bit_mode_reg <= 1'b0;
        else if (cfg_we)
            seven_bit_mode_reg <= cfg_wdata;
    end

    assign accept = in_valid && in_ready;

    // Decode the byte and advance the frame state in the accept cycle
    sfr_frame_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .seven_bit_mode (seven_bit_mode_reg),
        .accept         (accept),
        .rx_byte        (rx_byte),
        .result         (engine_result)
    );

    // Hold results until the consumer takes them
    sfr_out_buffer u_out_buffer (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (engine_result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_result)
    );

    assign status        = out_result.status;
    assign data_byte     = out_result.data_byte;
    assign data_index    = out_result.data_index;
    assign sector_number = out_result.sector_number;

    // Blocked input means a result is waiting in the output register
    a_stall_implies_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid
    ) else $error("input blocked with no result pending");

    // An accepted request into an empty buffer shows up next cycle
    a_accept_to_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && !out_valid) |=> out_valid
    ) else $error("accepted request did not reach the output");

    // Data fields are zero unless the result carries a data byte
    a_data_fields_clear: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DATA) |-> (data_byte == 8'h00 && data_index == 7'd0)
    ) else $error("data fields set on a non-data result");

    // Taking the last result with nothing new empties the output
    a_drain: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && in_ready && !accept) |=> !out_valid
    ) else $error("stale result after drain");

endmodule

// ----- hw/rtl/sfr_frame_engine.sv -----
// ----------------------------------------------------------------------------
// sfr_frame_engine
// Deframing state machine: phase, pair decoding, checksum and retry state.
// ----------------------------------------------------------------------------
module sfr_frame_engine
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seven_bit_mode,
    input  logic        accept,
    input  logic [7:0]  rx_byte,
    output sfr_result_t result
);

    phase_t             phase_reg, phase_next;
    logic [3:0]         high_nibble_reg, high_nibble_next;
    logic               pair_half_reg, pair_half_next;
    logic [CNT_W-1:0]   byte_count_reg, byte_count_next;
    logic [SUM_W-1:0]   running_sum_reg, running_sum_next;
    logic [3:0]         expected_sector_reg, expected_sector_next;
    logic [3:0]         retry_count_reg, retry_count_next;

    logic [7:0]         c;
    logic [7:0]         b;
    logic [7:0]         folded;
    logic [CNT_W-1:0]   count_inc;
    logic [3:0]         retry_inc;
    status_t            st;
    logic [7:0]         db;
    logic [6:0]         di;

    assign c         = seven_bit_mode ? {1'b0, rx_byte[6:0]} : rx_byte;
    assign b         = seven_bit_mode ? {high_nibble_reg, hex_value(c)} : c;
    assign folded    = running_sum_reg[7:0] + running_sum_reg[SUM_W-1:8];
    assign count_inc = byte_count_reg + 1'b1;
    assign retry_inc = retry_count_reg + 1'b1;

    always_comb
    begin
        phase_next           = phase_reg;
        high_nibble_next     = high_nibble_reg;
        pair_half_next       = pair_half_reg;
        byte_count_next      = byte_count_reg;
        running_sum_next     = running_sum_reg;
        expected_sector_next = expected_sector_reg;
        retry_count_next     = retry_count_reg;
        st                   = ST_NONE;
        db                   = 8'h00;
        di                   = 7'd0;

        unique case (phase_reg) inside
            PH_HEADER:
            begin
                if (c == CH_CANCEL)
                begin
                    phase_next = PH_HALT;
                    st         = ST_CANCEL;
                end
                else if (c == CH_EOT)
                begin
                    expected_sector_next = 4'd1;
                    retry_count_next     = 4'd0;
                    st                   = ST_EOT;
                end
                else if (c == CH_SOH)
                begin
                    phase_next       = PH_SECTOR;
                    running_sum_next = '0;
                    byte_count_next  = '0;
                    pair_half_next   = 1'b0;
                end
                else
                begin
                    phase_next = PH_HALT;
                    st         = ST_NOSOH;
                end
            end
            PH_SECTOR, PH_DATA, PH_CKSUM:
            begin
                if (seven_bit_mode && !pair_half_reg)
                begin
                    // first character of a pair: hold its nibble
                    high_nibble_next = hex_value(c);
                    pair_half_next   = 1'b1;
                end
                else
                begin
                    // a raw byte leaves a pending half pair untouched
                    if (seven_bit_mode)
                        pair_half_next = 1'b0;
                    if (phase_reg == PH_SECTOR)
                    begin
                        if (b != {4'h0, expected_sector_reg})
                        begin
                            phase_next = PH_HALT;
                            st         = ST_BADSEC;
                        end
                        else
                            phase_next = PH_DATA;
                    end
                    else if (phase_reg == PH_DATA)
                    begin
                        running_sum_next = running_sum_reg + {{(SUM_W-8){1'b0}}, b};
                        byte_count_next  = count_inc;
                        if (count_inc >= CNT_W'(SECTOR_BYTES))
                            phase_next = PH_CKSUM;
                        st = ST_DATA;
                        db = b;
                        di = byte_count_reg[6:0];
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        if (folded == b)
                        begin
                            expected_sector_next = expected_sector_reg + 4'd1;
                            retry_count_next     = 4'd0;
                            st                   = ST_ACK;
                        end
                        else
                        begin
                            retry_count_next = retry_inc;
                            if (retry_inc >= 4'(MAX_RETRIES))
                            begin
                                phase_next = PH_HALT;
                                st         = ST_TOOMANY;
                            end
                            else
                                st = ST_NAK;
                        end
                    end
                end
            end
            PH_HALT:
            begin
                st = ST_HALTED;
            end
            default:
            begin
                phase_next = PH_HALT;
                st         = ST_HALTED;
            end
        endcase
    end

    assign result.status        = st;
    assign result.data_byte     = db;
    assign result.data_index    = di;
    assign result.sector_number = expected_sector_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_HEADER;
            high_nibble_reg     <= 4'h0;
            pair_half_reg       <= 1'b0;
            byte_count_reg      <= '0;
            running_sum_reg     <= '0;
            expected_sector_reg <= 4'd1;
            retry_count_reg     <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg           <= phase_next;
            high_nibble_reg     <= high_nibble_next;
            pair_half_reg       <= pair_half_next;
            byte_count_reg      <= byte_count_next;
            running_sum_reg     <= running_sum_next;
            expected_sector_reg <= expected_sector_next;
            retry_count_reg     <= retry_count_next;
        end
    end

endmodule

// ----- hw/rtl/sfr_out_buffer.sv -----
// ----------------------------------------------------------------------------
// sfr_out_buffer
// Two-entry result buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module sfr_out_buffer
    import sfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sfr_result_t push_data,
    output logic        push_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output sfr_result_t out_data
);

    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    sfr_result_t out_data_reg, out_data_next;
    sfr_result_t skid_data_reg, skid_data_next;
    logic        pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                // advance skid entry into the output register
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
                out_data_next = push_data;
            else
                out_valid_next = 1'b0;
        end
        else if (!out_valid_reg)
        begin
            if (push)
            begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end
        end
        else if (push)
        begin
            skid_data_next  = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ----- tb/sfr_checker.sv -----
// ----------------------------------------------------------------------------
// sfr_checker
// Watches the request and result channels of the sector frame receiver,
// predicts every result from the accepted requests and compares them in order.
// ----------------------------------------------------------------------------
module sfr_checker
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] rx_byte,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [3:0] status,
    input  logic [7:0] data_byte,
    input  logic [6:0] data_index,
    input  logic [3:0] sector_number,
    input  logic       run_done,
    output int         failures
);

    localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
    localparam logic [7:0] CH_SEVEN = 8'h37; // '7'
    localparam int         SHOWN    = 50;

    // Shadow of the receiver state
    logic                 channel7;
    phase_t               rx_phase;
    logic [3:0]           pending_nibble;
    logic                 in_pair;
    logic [CNT_W-1:0]     sector_fill;
    logic [SUM_W-1:0]     data_sum;
    logic [3:0]           want_sector;
    logic [3:0]           nak_streak;

    sfr_result_t          pending_reports[$];
    sfr_result_t          want;
    logic                 closed;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = (c > CH_NINE) ? c - CH_SEVEN : c - CH_ZERO;
        return d[3:0];
    endfunction

    // Advance the shadow state by one request and queue the result it causes
    function automatic void deframe_rx_byte(input logic [7:0] raw);
        logic [7:0]  c;
        logic [7:0]  b;
        logic [7:0]  folded;
        sfr_result_t r;
        r = '0;
        r.status = ST_NONE;
        c = channel7 ? {1'b0, raw[6:0]} : raw;
        if (rx_phase == PH_HALT) begin
            r.status = ST_HALTED;
        end
        else if (rx_phase == PH_HEADER) begin
            if (c == CH_CANCEL) begin
                rx_phase = PH_HALT;
                r.status = ST_CANCEL;
            end
            else if (c == CH_EOT) begin
                want_sector = 4'd1;
                nak_streak  = '0;
                r.status    = ST_EOT;
            end
            else if (c == CH_SOH) begin
                rx_phase    = PH_SECTOR;
                data_sum    = '0;
                sector_fill = '0;
                in_pair     = 1'b0;
            end
            else begin
                rx_phase = PH_HALT;
                r.status = ST_NOSOH;
            end
        end
        else if (channel7 && !in_pair) begin
            pending_nibble = nibble_of(c);
            in_pair        = 1'b1;
        end
        else begin
            if (channel7) begin
                in_pair = 1'b0;
                b = {pending_nibble, nibble_of(c)};
            end
            else begin
                b = c;
            end
            if (rx_phase == PH_SECTOR) begin
                // full 8-bit compare: a matching low nibble alone is not enough
                if (b != {4'h0, want_sector}) begin
                    rx_phase = PH_HALT;
                    r.status = ST_BADSEC;
                end
                else begin
                    rx_phase = PH_DATA;
                end
            end
            else if (rx_phase == PH_DATA) begin
                r.status     = ST_DATA;
                r.data_byte  = b;
                r.data_index = sector_fill[6:0];
                data_sum     = data_sum + b;
                sector_fill  = sector_fill + 1'b1;
                if (sector_fill >= SECTOR_BYTES)
                    rx_phase = PH_CKSUM;
            end
            else begin
                folded   = data_sum[7:0] + data_sum[15:8];
                rx_phase = PH_HEADER;
                if (folded == b) begin
                    want_sector = want_sector + 1'b1;
                    nak_streak  = '0;
                    r.status    = ST_ACK;
                end
                else begin
                    nak_streak = nak_streak + 1'b1;
                    if (nak_streak >= MAX_RETRIES) begin
                        rx_phase = PH_HALT;
                        r.status = ST_TOOMANY;
                    end
                    else begin
                        r.status = ST_NAK;
                    end
                end
            end
        end
        r.sector_number = want_sector;
        pending_reports.push_back(r);
    endfunction

    task automatic report_mismatch(input string what);
        failures++;
        if (failures <= SHOWN)
            $display("%0t sfr_checker: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            channel7       = 1'b0;
            rx_phase       = PH_HEADER;
            pending_nibble = '0;
            in_pair        = 1'b0;
            sector_fill    = '0;
            data_sum       = '0;
            want_sector    = 4'd1;
            nak_streak     = '0;
            closed         = 1'b0;
            failures       = 0;
            pending_reports.delete();
        end
        else begin
            if (out_valid && out_ready) begin
                if (pending_reports.size() == 0) begin
                    report_mismatch($sformatf("result status %0d with nothing pending", status));
                end
                else begin
                    want = pending_reports.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  status, want.status));
                    if (data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte %02h, want %02h",
                                                  data_byte, want.data_byte));
                    if (data_index !== want.data_index)
                        report_mismatch($sformatf("data_index %0d, want %0d",
                                                  data_index, want.data_index));
                    if (sector_number !== want.sector_number)
                        report_mismatch($sformatf("sector_number %0d, want %0d",
                                                  sector_number, want.sector_number));
                end
            end
            // a request taken at this edge still sees the old mode
            if (in_valid && in_ready)
                deframe_rx_byte(rx_byte);
            if (cfg_we)
                channel7 = cfg_wdata;
            if (run_done && !closed) begin
                closed = 1'b1;
                if (pending_reports.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              pending_reports.size()));
            end
        end
    end

endmodule

// ----- tb/sector_frame_receiver_core_tb.sv -----
// ----------------------------------------------------------------------------
// sector_frame_receiver_core_tb
// Feeds the sector frame receiver with framed sectors in both channel modes,
// with random content, bad checksums, mode switches and random flow control,
// and ends with one randomly chosen fatal condition; sfr_checker compares.
// ----------------------------------------------------------------------------
module sector_frame_receiver_core_tb;
    import sfr_pkg::*;

    // Ways to end the run: each one halts the receiver for good
    typedef enum int {
        FIN_CANCEL,
        FIN_NO_SOH,
        FIN_BAD_SECTOR,
        FIN_RETRIES
    } finale_t;

    localparam int HOLD_CYCLES = 60;
    localparam int RANDOM_ITEMS = 1600;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [3:0] status;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic [3:0] sector_number;
    logic       run_done;
    int         failures;

    // Flow bookkeeping: requests taken versus results taken
    int unsigned n_sent;
    int unsigned n_results;
    bit          steady;
    int          holds_wanted = 0;
    int          holds_done = 0;

    // What the sender needs to build well-formed sectors
    bit          seven_bit;
    logic [3:0]  next_sec;
    int          nak_run;
    logic [15:0] frame_sum;
    int          frame_len;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    sector_frame_receiver_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_byte     (data_byte),
        .data_index    (data_index),
        .sector_number (sector_number)
    );

    sfr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_byte     (data_byte),
        .data_index    (data_index),
        .sector_number (sector_number),
        .run_done      (run_done),
        .failures      (failures)
    );

    // Count results as they leave; the sender drains against this
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_results <= 0;
        else if (out_valid && out_ready)
            n_results <= n_results + 1;
    end

    // Result side: random back-pressure, a quiet stretch while steady is set,
    // and a long hold-off whenever the sender asks for one.  The hold is
    // counted here so the sender keeps offering and the block fills up.
    initial
    begin
        int hold_count;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_wanted)
            begin
                out_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
                    @(negedge clk);
                holds_done++;
            end
            else
            begin
                out_ready <= steady || ($urandom_range(99) >= 30);
            end
        end
    end

    // A random character that decodes to the nibble: control codes, digits, letters
    // of either case and punctuation, with bit 7 set at random since the line masks it
    function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
        logic [2:0] zone;
        logic [7:0] glyph;
        zone = $urandom_range(7);
        if (zone <= 3'd2 || (zone == 3'd3 && nib <= 4'd9))
        begin
            glyph = {1'b0, zone, nib};
        end
        else
        begin
            if (zone == 3'd3)
                zone = 3'd4;
            // above '9' the decode subtracts '7', so pre-add seven
            glyph = {1'b0, zone, nib + 4'd7};
        end
        glyph[7] = $urandom_range(1);
        return glyph;
    endfunction

    // A control character as it may appear on the line in the current mode
    function automatic logic [7:0] on_line(input logic [7:0] ch);
        logic [7:0] v;
        v = ch;
        if (seven_bit)
            v[7] = $urandom_range(1);
        return v;
    endfunction

    // Offer one request; hold valid and payload until it is taken
    task automatic offer_byte(input logic [7:0] value);
        int gap;
        @(negedge clk);
        if (!steady && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 3);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do @(posedge clk); while (!in_ready);
        n_sent++;
    endtask

    // One decoded byte: raw in eight-bit mode, a character pair otherwise
    task automatic offer_coded(input logic [7:0] value);
        if (seven_bit)
        begin
            offer_byte(hex_glyph(value[7:4]));
            offer_byte(hex_glyph(value[3:0]));
        end
        else
        begin
            offer_byte(value);
        end
    endtask

    // Drop valid and hold until every request has had its result
    task automatic wait_results_home();
        @(negedge clk);
        in_valid <= 1'b0;
        while (n_results != n_sent)
            @(posedge clk);
    endtask

    // Switch channel mode only once the block has gone quiet
    task automatic select_channel(input bit mode);
        wait_results_home();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
        seven_bit = mode;
    endtask

    task automatic open_sector();
        offer_byte(on_line(CH_SOH));
        offer_coded({4'h0, next_sec});
        frame_sum = '0;
        frame_len = 0;
    endtask

    task automatic append_payload(input logic [7:0] value);
        offer_coded(value);
        frame_sum = frame_sum + value;
        frame_len++;
    endtask

    // Fill the sector with random bytes, flipping the mode at switch_at
    task automatic fill_sector(input int switch_at);
        while (frame_len < SECTOR_BYTES)
        begin
            if (frame_len == switch_at)
                select_channel(!seven_bit);
            append_payload($urandom_range(255));
        end
    endtask

    // Send the folded checksum, or a spoilt one, and track what follows
    task automatic close_sector(input bit good);
        logic [7:0] ck;
        logic [7:0] spoil;
        ck = frame_sum[7:0] + frame_sum[15:8];
        if (!good)
        begin
            spoil = $urandom_range(255, 1);
            ck = ck ^ spoil;
        end
        offer_coded(ck);
        if (good)
        begin
            next_sec = next_sec + 1'b1;
            nak_run  = 0;
        end
        else
        begin
            nak_run++;
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        int         frame_no;
        int         r;
        finale_t    finale;
        logic [7:0] stray;
        logic [7:0] seen;
        logic [7:0] wrong;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        run_done  = 1'b0;
        steady    = 1'b0;
        seven_bit = 1'b0;
        next_sec  = 4'd1;
        nak_run   = 0;
        n_sent    = 0;
        frame_sum = '0;
        frame_len = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: EOT in both modes, extreme data values,
        // lower-case hex, and a mode flip in the middle of a pair
        select_channel(1'b0);
        offer_byte(CH_EOT);
        select_channel(1'b1);
        offer_byte(CH_EOT | 8'h80);
        open_sector();
        append_payload(8'h00);
        append_payload(8'hFF);
        offer_byte(8'h66);              // lower-case f
        offer_byte(8'h66);
        frame_sum = frame_sum + 8'hFF;
        frame_len++;
        append_payload(8'h7F);
        append_payload(8'h80);
        // first half '5', then a raw byte, then the second half 'C':
        // the stored nibble survives the detour through eight-bit mode
        offer_byte(8'h35);
        select_channel(1'b0);
        append_payload(8'hA5);
        select_channel(1'b1);
        offer_byte(8'h43);
        frame_sum = frame_sum + 8'h5C;
        frame_len++;
        fill_sector(SECTOR_BYTES);
        close_sector(1'b1);
        select_channel(1'b0);
        open_sector();
        fill_sector(SECTOR_BYTES);
        close_sector(1'b0);

        // Random sectors until the item budget is spent
        frame_no = 0;
        while (n_sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                offer_byte(on_line(CH_EOT));
                next_sec = 4'd1;
                nak_run  = 0;
            end
            else if (r < 20)
            begin
                select_channel($urandom_range(1));
            end
            else if (r < 24)
            begin
                // let everything drain before carrying on
                wait_results_home();
            end
            steady = (frame_no == 5 || frame_no == 6);
            open_sector();
            // stall the result side while requests keep coming
            if (frame_no == 3)
                holds_wanted++;
            fill_sector(($urandom_range(9) == 0) ? $urandom_range(1, 127) : SECTOR_BYTES);
            // never let the retry count reach its limit here
            close_sector(nak_run >= MAX_RETRIES - 1 || $urandom_range(99) >= 25);
            frame_no++;
        end
        steady = 1'b0;

        // Finish with one fatal condition, then check the halted answer
        finale = finale_t'($urandom_range(3));
        case (finale)
            FIN_CANCEL:
            begin
                offer_byte(on_line(CH_CANCEL));
            end
            FIN_NO_SOH:
            begin
                do
                begin
                    stray = $urandom_range(255);
                    seen  = seven_bit ? {1'b0, stray[6:0]} : stray;
                end
                while (seen == CH_SOH || seen == CH_EOT || seen == CH_CANCEL);
                offer_byte(stray);
            end
            FIN_BAD_SECTOR:
            begin
                offer_byte(on_line(CH_SOH));
                if ($urandom_range(1))
                begin
                    // right low nibble, wrong high nibble
                    wrong[3:0] = next_sec;
                    wrong[7:4] = $urandom_range(15, 1);
                end
                else
                begin
                    do wrong = $urandom_range(255); while (wrong == {4'h0, next_sec});
                end
                offer_coded(wrong);
            end
            default:
            begin
                while (nak_run < MAX_RETRIES)
                begin
                    open_sector();
                    fill_sector(SECTOR_BYTES);
                    close_sector(1'b0);
                end
            end
        endcase
        repeat (20) offer_byte($urandom_range(255));

        wait_results_home();
        repeat (4) @(negedge clk);
        run_done <= 1'b1;
        repeat (2) @(negedge clk);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
